// ===== rtl/core/postfix_expression_evaluator_top_defines.svh =====
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFX_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PFX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pfx_pkg.sv =====
package pfx_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int SYM_W       = 8;
  localparam int VAL_W       = 32;
  localparam int DEPTH_OUT_W = 5;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'd48;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'd57;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;

  typedef struct packed {
    logic                load_in;
    logic                push;
    logic                rd_second;
    logic                alu_cap;
    logic                div_start;
    logic                div_cap;
    logic                commit;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } pfx_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic full;
    logic lt2;
    logic n2_zero;
    logic div_done;
  } pfx_sts_t;

endpackage

// ===== rtl/core/pfx_div.sv =====
module pfx_div
  import pfx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(VAL_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] quo_r, quo_nxt;
  logic [VAL_W-1:0] dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W:0]   shifted;
  logic [VAL_W+1:0] diff;

  assign shifted = {rem_r, quo_r[VAL_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VAL_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend[VAL_W-1] ? (VAL_W'(0) - dividend) : dividend;
      dvs_nxt  = divisor[VAL_W-1] ? (VAL_W'(0) - divisor) : divisor;
      neg_nxt  = dividend[VAL_W-1] ^ divisor[VAL_W-1];
    end else if (busy_r) begin
      if (!diff[VAL_W+1]) begin
        rem_nxt = diff[VAL_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VAL_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (VAL_W'(0) - quo_r) : quo_r;

endmodule

// ===== rtl/core/pfx_dp.sv =====
module pfx_dp
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pfx_cmd_t               cmd,
  output pfx_sts_t               sts,
  input  logic [SYM_W-1:0]       in_symbol,
  input  logic                   in_last,
  output logic [VAL_W-1:0]       out_top,
  output logic [DEPTH_OUT_W-1:0] out_depth,
  output logic [STATUS_W-1:0]    out_status,
  output logic                   out_last
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [VAL_W-1:0] stack_mem [STACK_DEPTH];

  logic [SYM_W-1:0]       sym_r;
  logic                   last_r;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [VAL_W-1:0]       top_r;
  logic [VAL_W-1:0]       rd_data_r;
  logic [VAL_W-1:0]       res_r;
  logic [VAL_W-1:0]       alu_res;
  logic [VAL_W-1:0]       div_q;
  logic                   div_done;
  logic [VAL_W-1:0]       out_top_r;
  logic [DEPTH_OUT_W-1:0] out_depth_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic                   out_last_r;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;

  assign wr_addr = AW'(depth_r - DW'(1));
  assign rd_addr = AW'(depth_r - DW'(2));

  always_comb begin
    sts.is_digit = sym_r inside {[SYM_ZERO:SYM_NINE]};
    sts.is_op    = sym_r inside {SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV};
    sts.is_div   = (sym_r == SYM_DIV);
    sts.full     = (depth_r == DW'(STACK_DEPTH));
    sts.lt2      = (depth_r < DW'(2));
    sts.n2_zero  = (top_r == '0);
    sts.div_done = div_done;
  end

  always_comb begin
    case (sym_r)
      SYM_PLUS:  alu_res = rd_data_r + top_r;
      SYM_MINUS: alu_res = rd_data_r - top_r;
      SYM_MUL:   alu_res = rd_data_r * top_r;
      default:   alu_res = '0;
    endcase
  end

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_data_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (cmd.commit) begin
      depth_nxt = depth_r - DW'(1);
    end else if (cmd.load_out && last_r) begin
      depth_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && depth_r != '0) begin
      stack_mem[wr_addr] <= top_r;
    end
    if (cmd.rd_second) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (cmd.push) begin
      top_r <= VAL_W'(sym_r - SYM_ZERO);
    end else if (cmd.commit) begin
      top_r <= res_r;
    end
    if (cmd.alu_cap) begin
      res_r <= alu_res;
    end else if (cmd.div_cap) begin
      res_r <= div_q;
    end
    if (cmd.load_out) begin
      out_top_r    <= (depth_r == '0) ? '0 : top_r;
      out_depth_r  <= DEPTH_OUT_W'(depth_r);
      out_status_r <= cmd.status;
      out_last_r   <= last_r;
    end
  end

  assign out_top    = out_top_r;
  assign out_depth  = out_depth_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/core/pfx_ctrl.sv =====
module pfx_ctrl
  import pfx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  pfx_sts_t sts,
  output pfx_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_OPR  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        status_nxt = ST_OK;
        state_nxt  = S_OUT;
        if (sts.is_digit) begin
          if (sts.full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (sts.is_op) begin
          if (sts.lt2) begin
            status_nxt = ST_UNDERFLOW;
          end else if (sts.is_div && sts.n2_zero) begin
            status_nxt = ST_DIVZERO;
          end else begin
            cmd.rd_second = 1'b1;
            state_nxt     = S_OPR;
          end
        end else begin
          status_nxt = ST_UNKNOWN;
        end
      end
      S_OPR: begin
        if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.alu_cap = 1'b1;
          state_nxt   = S_WB;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_WB;
        end
      end
      S_WB: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/postfix_expression_evaluator_top.sv =====
// Channel   Direction  tdata                                 tuser       tlast
// in_       slave      [7:0] symbol                          -           end_of_expr
// out_      master     [31:0] top_value, [36:32] stack_depth [2:0] status expr_done
//
// One item at a time. Digit or faulting symbol: decode, output. + - *: decode,
// operate, write-back, output; divide adds the radix-2 divider (32 iterations).
// The second operand comes from a stack memory with registered read;
// the top of stack lives in a register.
// Reset empties the stack; the stack memory holds no reset value.
// in_tready rises again once the item's result has entered the output register.
module postfix_expression_evaluator_top
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] symbol
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] top_value, [36:32] stack_depth
  output logic [STATUS_W-1:0]    out_tuser,  // [2:0] status
  output logic                   out_tlast
);

  pfx_cmd_t               cmd;
  pfx_sts_t               sts;
  logic [VAL_W-1:0]       top_value;
  logic [DEPTH_OUT_W-1:0] stack_depth;

  pfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfx_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_symbol  (in_tdata[SYM_W-1:0]),
    .in_last    (in_tlast),
    .out_top    (top_value),
    .out_depth  (stack_depth),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - VAL_W - DEPTH_OUT_W){1'b0}}, stack_depth, top_value};

endmodule

// ===== rtl/core/postfix_expression_evaluator_chk.sv =====
`include "postfix_expression_evaluator_top_defines.svh"

module postfix_expression_evaluator_chk
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser,
  input logic                   out_tlast
);

  localparam bit SMALL = (STACK_DEPTH < 32);

  `PFX_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")
  `PFX_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken before result")
  `PFX_ASSERT(a_depth_max, out_tvalid && SMALL, out_tdata[36:32] <= 5'(STACK_DEPTH), "depth above stack size")
  `PFX_ASSERT(a_empty_top, out_tvalid && SMALL && out_tdata[36:32] == 5'd0, out_tdata[31:0] == 32'd0, "empty stack shows nonzero top")
  `PFX_ASSERT(a_underflow, out_tvalid && out_tuser == ST_UNDERFLOW, out_tdata[36:32] < 5'd2, "underflow with two or more entries")

endmodule

bind postfix_expression_evaluator_top postfix_expression_evaluator_chk #(
  .STACK_DEPTH (STACK_DEPTH)
) u_chk (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pfx_pkg::*;

  localparam int TOTAL_ITEMS = 1975;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 60;
  localparam int PRINT_LIMIT = 100;

  localparam logic [SYM_W-1:0] OPERATORS [4] = '{SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV};

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]       top;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [STATUS_W-1:0]    status;
    logic                   done;
  } eval_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  sym_item_t    pending_q [$];
  eval_result_t result_q [$];

  logic [VAL_W-1:0] eval_stack [STACK_DEPTH_DEF];
  int               eval_depth = 0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   in_wait = 0;
  int   in_calm = 0;
  int   out_wait = 0;
  int   out_calm = 0;
  int   items_in = 0;
  int   results_out = 0;
  int   idle_cycles = 0;
  int   n_errors = 0;
  int   total_items = 0;

  postfix_expression_evaluator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic eval_result_t eval_symbol(input logic [SYM_W-1:0] sym, input logic last);
    eval_result_t     r;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] ma;
    logic [VAL_W-1:0] mb;
    logic [VAL_W-1:0] q;
    logic [VAL_W-1:0] v;
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    v  = '0;
    if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
      if (eval_depth >= STACK_DEPTH_DEF) begin
        st = ST_OVERFLOW;
      end else begin
        eval_stack[eval_depth] = {{(VAL_W-SYM_W){1'b0}}, sym - SYM_ZERO};
        eval_depth++;
      end
    end else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_MUL || sym == SYM_DIV) begin
      if (eval_depth < 2) begin
        st = ST_UNDERFLOW;
      end else begin
        b = eval_stack[eval_depth-1];
        a = eval_stack[eval_depth-2];
        case (sym)
          SYM_PLUS:  v = a + b;
          SYM_MINUS: v = a - b;
          SYM_MUL:   v = a * b;
          default: begin
            if (b == '0) begin
              st = ST_DIVZERO;
            end else begin
              ma = a[VAL_W-1] ? -a : a;
              mb = b[VAL_W-1] ? -b : b;
              q  = ma / mb;
              v  = (a[VAL_W-1] ^ b[VAL_W-1]) ? -q : q;
            end
          end
        endcase
        if (st == ST_OK) begin
          eval_depth--;
          eval_stack[eval_depth-1] = v;
        end
      end
    end else begin
      st = ST_UNKNOWN;
    end
    r.top    = (eval_depth > 0) ? eval_stack[eval_depth-1] : '0;
    r.depth  = DEPTH_OUT_W'(eval_depth);
    r.status = st;
    r.done   = last;
    if (last) eval_depth = 0;
    return r;
  endfunction

  function automatic int draw_wait(inout int calm);
    int w;
    if (calm > 0) begin
      calm--;
      w = 0;
    end else begin
      w = $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 60);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic add_sym(input logic [SYM_W-1:0] s, input logic l);
    sym_item_t it;
    it.symbol = s;
    it.last   = l;
    pending_q.push_back(it);
  endtask

  task automatic add_digit();
    add_sym(SYM_ZERO + SYM_W'($urandom_range(0, 9)), 1'b0);
  endtask

  task automatic add_operator();
    add_sym(OPERATORS[$urandom_range(0, 3)], 1'b0);
  endtask

  task automatic add_noise();
    add_sym(SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic close_run();
    if ($urandom_range(0, 7) != 0) pending_q[$].last = 1'b1;
  endtask

  task automatic add_expression();
    int operands;
    int depth;
    int pushed;
    operands = $urandom_range(1, 12);
    depth    = 0;
    pushed   = 0;
    while (pushed < operands || depth > 1) begin
      if ($urandom_range(0, 11) == 0) add_noise();
      if (depth < 2 || (pushed < operands && $urandom_range(0, 1) == 0)) begin
        add_digit();
        depth++;
        pushed++;
      end else begin
        add_operator();
        depth--;
      end
    end
    close_run();
  endtask

  task automatic add_overflow_run();
    int n;
    n = $urandom_range(STACK_DEPTH_DEF, STACK_DEPTH_DEF + 3);
    repeat (n) add_digit();
    repeat ($urandom_range(0, 3)) add_operator();
    close_run();
  endtask

  // build 2**31 (most negative value), then divide it by -1
  task automatic add_min_quotient_run();
    add_sym(SYM_ZERO + 8'd2, 1'b0);
    repeat (10) begin
      add_sym(SYM_ZERO + 8'd8, 1'b0);
      add_sym(SYM_MUL, 1'b0);
    end
    add_sym(SYM_ZERO, 1'b0);
    add_sym(SYM_ZERO + 8'd1, 1'b0);
    add_sym(SYM_MINUS, 1'b0);
    add_sym(SYM_DIV, 1'b0);
    repeat ($urandom_range(0, 2)) begin
      add_digit();
      add_operator();
    end
    close_run();
  endtask

  always @(negedge clk) begin : drive_symbols
    sym_item_t nxt;
    if (rst_n) begin
      if (in_fire) in_wait = draw_wait(in_calm);
      if (!in_tvalid || in_fire) begin
        if (in_wait > 0) begin
          in_tvalid <= 1'b0;
          in_wait = in_wait - 1;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.symbol;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (out_fire) out_wait = draw_wait(out_calm);
      if (out_wait > 0) begin
        out_tready <= 1'b0;
        out_wait = out_wait - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    eval_result_t want;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_tvalid && in_tready;
      out_fire <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        result_q.push_back(eval_symbol(in_tdata[SYM_W-1:0], in_tlast));
        items_in++;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: tdata=%h tuser=%0d tlast=%b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          want = result_q.pop_front();
          if (out_tdata[31:0] !== want.top || out_tdata[36:32] !== want.depth ||
              out_tuser !== want.status || out_tlast !== want.done) begin
            report_mismatch($sformatf(
              "result %0d: top %0d/%0d depth %0d/%0d status %0d/%0d done %b/%b",
              results_out, $signed(out_tdata[31:0]), $signed(want.top),
              out_tdata[36:32], want.depth, out_tuser, want.status, out_tlast, want.done));
          end
        end
        results_out++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[%0t] timeout: no item moved for %0d cycles", $time, IDLE_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    add_sym(SYM_PLUS, 1'b0);
    add_sym(SYM_ZERO + 8'd5, 1'b0);
    add_sym(SYM_DIV, 1'b0);
    add_sym(8'h00, 1'b0);
    add_sym(8'hFF, 1'b0);
    add_sym(SYM_ZERO, 1'b0);
    add_sym(SYM_DIV, 1'b0);
    add_sym(SYM_NINE, 1'b0);
    add_sym(SYM_MINUS, 1'b0);
    add_sym(SYM_MUL, 1'b0);
    add_sym(SYM_ZERO + 8'd7, 1'b0);
    add_sym(SYM_DIV, 1'b0);
    add_sym(SYM_ZERO + 8'd2, 1'b0);
    add_sym(SYM_PLUS, 1'b0);
    add_sym(8'h40, 1'b1);
    add_sym(SYM_DIV, 1'b1);
    add_sym(SYM_NINE + 8'd1, 1'b0);
    add_sym(SYM_ZERO - 8'd2, 1'b0);
    add_sym(SYM_ZERO, 1'b0);
    add_sym(SYM_ZERO + 8'd7, 1'b0);
    add_sym(SYM_MINUS, 1'b0);
    add_sym(SYM_ZERO, 1'b0);
    add_sym(SYM_ZERO + 8'd2, 1'b0);
    add_sym(SYM_MINUS, 1'b0);
    add_sym(SYM_DIV, 1'b1);
    add_min_quotient_run();
    add_overflow_run();

    while (pending_q.size() < TOTAL_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       add_overflow_run();
        1:       add_min_quotient_run();
        2, 3:    repeat ($urandom_range(1, 4)) add_noise();
        default: add_expression();
      endcase
    end
    total_items = pending_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_in < total_items || result_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
